/* rtl/lpi_pkg.sv */
// Shared constants, types and helpers for the two-point line and plane crossing block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package lpi_pkg;

  // Default formats and fixed field widths.
  localparam int POS_WIDTH_DEF       = 32;
  localparam int SLOPE_FRAC_BITS_DEF = 24;
  localparam int FIELD_W             = 32;
  localparam int CFG_IDX_W           = 2;

  // Chunk size of the A operand in the pipelined multiplier.
  localparam int MUL_CHUNK = 24;

  // Working width of the saturation helper.
  localparam int SAT_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILT_X = 2'd0,
    REG_TILT_Y = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_t;

  // One result transaction as it sits in the output register.
  typedef struct packed {
    logic [FIELD_W-1:0] slope_x;
    logic [FIELD_W-1:0] slope_y;
    logic [FIELD_W-1:0] origin_x;
    logic [FIELD_W-1:0] origin_y;
    logic [FIELD_W-1:0] cross_x;
    logic [FIELD_W-1:0] cross_y;
    logic [FIELD_W-1:0] cross_z;
    logic               flat_pair;
    logic               no_crossing;
  } lpi_result_t;

  // Clamp a signed value to the range of a w-bit signed number.
  function automatic logic signed [SAT_W-1:0] sat_w(input logic signed [SAT_W-1:0] v,
                                                    input int unsigned w);
    logic signed [SAT_W-1:0] one;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    one = SAT_W'(1);
    hi  = (one <<< (w - 1)) - one;
    lo  = -hi - one;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/lpi_mul.sv */
// Two-stage signed multiplier: A is cut into chunks, partial products are registered,
// then summed into the registered product. Depends on lpi_pkg.
`default_nettype none

module lpi_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import lpi_pkg::*;

  localparam int CH  = MUL_CHUNK;
  localparam int NCH = (AW + CH - 1) / CH;
  localparam int AXW = NCH * CH;
  localparam int PW  = CH + 1 + BW;
  localparam int OW  = AW + BW;

  logic signed [AXW-1:0] a_ext;
  logic signed [PW-1:0]  ax  [NCH];
  logic signed [PW-1:0]  bx;
  logic signed [PW-1:0]  pp_r [NCH];
  logic signed [OW-1:0]  sum;
  logic signed [OW-1:0]  p_r;

  assign a_ext = AXW'(a);
  assign bx    = PW'(b);

  // Lower chunks are unsigned, the top chunk carries the sign.
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      if (k == NCH - 1) begin
        ax[k] = PW'($signed(a_ext[k*CH +: CH]));
      end else begin
        ax[k] = PW'($signed({1'b0, a_ext[k*CH +: CH]}));
      end
    end
  end

  // Partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCH; k++) begin
        pp_r[k] <= ax[k] * bx;
      end
    end
  end

  // Weighted sum of the partial products.
  always_comb begin
    sum = '0;
    for (int k = 0; k < NCH; k++) begin
      sum = sum + (OW'(pp_r[k]) <<< (k * CH));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* rtl/lpi_div.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// The quotient magnitude saturates at QB bits. Depends on lpi_pkg.
`default_nettype none

module lpi_div #(
  parameter int NW = 65,
  parameter int DW = 33,
  parameter int QB = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  input  logic          flip,
  output logic [QB:0]   q
);
  import lpi_pkg::*;

  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [NW-1:0] a_un_r;
  logic [DW-1:0] a_ud_r;
  logic          a_neg_r;
  logic [CW-1:0] hi_ext;
  logic [CW-1:0] ud_ext;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] nq_r  [QB+1];
  logic [DW-1:0] ud_r  [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];

  logic [QB-1:0] mag;
  logic [QB:0]   q_r;

  // Magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      a_un_r  <= n[NW-1] ? (~n + NW'(1)) : n;
      a_ud_r  <= d[DW-1] ? (~d + DW'(1)) : d;
      a_neg_r <= n[NW-1] ^ d[DW-1] ^ flip;
    end
  end

  // The quotient overflows QB bits when the upper numerator part reaches the divisor.
  assign hi_ext = CW'(a_un_r[NW-1:QB]);
  assign ud_ext = CW'(a_ud_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= hi_ext >= ud_ext;
      rem_r[0] <= hi_ext[DW-1:0];
      nq_r[0]  <= a_un_r[QB-1:0];
      ud_r[0]  <= a_ud_r;
      neg_r[0] <= a_neg_r;
    end
  end

  // Restoring steps: numerator bits shift out the top, quotient bits shift in below.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_r[k], nq_r[k][QB-1]};
    assign diff  = trial - {1'b0, ud_r[k]};
    assign ge    = trial >= {1'b0, ud_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[k+1]  <= {nq_r[k][QB-2:0], ge};
        ud_r[k+1]  <= ud_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // Saturate and apply the sign.
  assign mag = ovf_r[QB] ? '1 : nq_r[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[QB] ? (~{1'b0, mag} + (QB+1)'(1)) : {1'b0, mag};
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* rtl/lpi_delay.sv */
// Delay line that carries a valid bit and its payload alongside a pipelined unit.
// Depends on lpi_pkg.
`default_nettype none

module lpi_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  logic [W-1:0] in_d,
  output logic         out_v,
  output logic [W-1:0] out_d
);
  import lpi_pkg::*;

  logic         v_r [N];
  logic [W-1:0] d_r [N];

  // Valid bits are control state and reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < N; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // Payload follows without reset.
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= in_d;
      for (int k = 1; k < N; k++) begin
        d_r[k] <= d_r[k-1];
      end
    end
  end

  assign out_v = v_r[N-1];
  assign out_d = d_r[N-1];

endmodule

`default_nettype wire

/* rtl/two_point_line_plane_intersect_core.sv */
// Two-point line fit and line-plane crossing, fully pipelined.
// Depends on lpi_pkg, lpi_mul, lpi_div and lpi_delay.
//
// Usage: each input transaction carries two hit points (Q24.8). The block fits
// x = slope_x*z + origin_x, y = slope_y*z + origin_y through them and crosses that
// line with the plane a*x + b*y + z + c = 0 set by the three cfg registers.
// Both channels move a transaction when valid is high and stall is low.
// Throughput is one transaction per cycle while in_stall is low; every divider
// stage resolves one quotient bit, so the two divider chains set the depth.
// The user must write the cfg registers only while no transaction is in flight;
// the block itself does not enforce this.
// Reset (synchronous, active low) clears the cfg registers to zero and empties the
// pipeline. When the receiver stalls, a skid register takes one more result;
// once it is full, in_stall rises and the whole pipeline holds without loss.
`default_nettype none

module two_point_line_plane_intersect_core #(
  parameter int POS_WIDTH       = lpi_pkg::POS_WIDTH_DEF,
  parameter int SLOPE_FRAC_BITS = lpi_pkg::SLOPE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpi_pkg::FIELD_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpi_pkg::FIELD_W-1:0]   in_left_x,
  input  logic [lpi_pkg::FIELD_W-1:0]   in_left_y,
  input  logic [lpi_pkg::FIELD_W-1:0]   in_left_z,
  input  logic [lpi_pkg::FIELD_W-1:0]   in_right_x,
  input  logic [lpi_pkg::FIELD_W-1:0]   in_right_y,
  input  logic [lpi_pkg::FIELD_W-1:0]   in_right_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpi_pkg::FIELD_W-1:0]   out_slope_x,
  output logic [lpi_pkg::FIELD_W-1:0]   out_slope_y,
  output logic [lpi_pkg::FIELD_W-1:0]   out_origin_x,
  output logic [lpi_pkg::FIELD_W-1:0]   out_origin_y,
  output logic [lpi_pkg::FIELD_W-1:0]   out_cross_x,
  output logic [lpi_pkg::FIELD_W-1:0]   out_cross_y,
  output logic [lpi_pkg::FIELD_W-1:0]   out_cross_z,
  output logic                          out_flat_pair,
  output logic                          out_no_crossing
);
  import lpi_pkg::*;

  localparam int P     = POS_WIDTH;
  localparam int S     = SLOPE_FRAC_BITS;
  localparam int FW    = FIELD_W;
  localparam int DFW   = FW + 1;
  localparam int PRW   = 2 * FW;
  localparam int NUM1W = (DFW + S > PRW + 1) ? DFW + S : PRW + 1;
  localparam int QB1   = (P > FW) ? P : FW;
  localparam int L1    = QB1 + 3;
  localparam int NUMW  = ((P + FW > FW + S) ? P + FW : FW + S) + 2;
  localparam int DENW  = ((2 * FW > 2 * S + 1) ? 2 * FW : 2 * S + 1) + 2;
  localparam int NUM2W = NUMW + ((FW > S) ? FW : S);
  localparam int QB2   = P + 1;
  localparam int L2    = QB2 + 3;
  localparam int W1    = 3 * DFW + 2 * FW;
  localparam int W2    = 1 + 2 * FW;
  localparam int W3    = 2 * FW + 2 * P + 1;
  localparam int W4    = NUMW + DENW + W3;
  localparam int W5    = W3 + 1;

  localparam logic signed [DENW-1:0] DEN_ONE = DENW'(1) <<< (2 * S);

  // Pipeline advance: everything moves unless the skid register is occupied.
  logic adv;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic signed [FW-1:0] tilt_x_r;
  logic signed [FW-1:0] tilt_y_r;
  logic signed [FW-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_x_r <= '0;
      tilt_y_r <= '0;
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TILT_X: tilt_x_r <= cfg_data;
        REG_TILT_Y: tilt_y_r <= cfg_data;
        REG_OFFSET: offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register.
  logic                 s1_v_r;
  logic signed [FW-1:0] lx_r, ly_r, lz_r, rx_r, ry_r, rz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r <= in_left_x;
      ly_r <= in_left_y;
      lz_r <= in_left_z;
      rx_r <= in_right_x;
      ry_r <= in_right_y;
      rz_r <= in_right_z;
    end
  end

  // Cross products for the origins.
  logic signed [PRW-1:0] p_rzlx, p_lzrx, p_rzly, p_lzry;

  lpi_mul #(.AW(FW), .BW(FW)) u_mul_rzlx (.clk, .en(adv), .a(rz_r), .b(lx_r), .p(p_rzlx));
  lpi_mul #(.AW(FW), .BW(FW)) u_mul_lzrx (.clk, .en(adv), .a(lz_r), .b(rx_r), .p(p_lzrx));
  lpi_mul #(.AW(FW), .BW(FW)) u_mul_rzly (.clk, .en(adv), .a(rz_r), .b(ly_r), .p(p_rzly));
  lpi_mul #(.AW(FW), .BW(FW)) u_mul_lzry (.clk, .en(adv), .a(lz_r), .b(ry_r), .p(p_lzry));

  // Differences travel beside the multipliers.
  logic signed [DFW-1:0] dz_w, dx_w, dy_w;
  logic                  d1_v;
  logic [W1-1:0]         d1_d;
  logic signed [DFW-1:0] d1_dz, d1_dx, d1_dy;
  logic signed [FW-1:0]  d1_rx, d1_ry;

  assign dz_w = DFW'(rz_r) - DFW'(lz_r);
  assign dx_w = DFW'(rx_r) - DFW'(lx_r);
  assign dy_w = DFW'(ry_r) - DFW'(ly_r);

  lpi_delay #(.W(W1), .N(2)) u_dly1 (
    .clk, .rst_n, .en(adv), .in_v(s1_v_r), .in_d({dz_w, dx_w, dy_w, rx_r, ry_r}),
    .out_v(d1_v), .out_d(d1_d)
  );

  assign {d1_dz, d1_dx, d1_dy, d1_rx, d1_ry} = d1_d;

  // ---------------------------------------------------------------------------
  // Stage 3: dividends for slopes and origins.
  logic                    s3_v_r;
  logic signed [NUM1W-1:0] sx_num_r, sy_num_r, ox_num_r, oy_num_r;
  logic signed [DFW-1:0]   dz3_r;
  logic                    flat3_r;
  logic signed [FW-1:0]    rx3_r, ry3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_num_r <= NUM1W'(d1_dx) <<< S;
      sy_num_r <= NUM1W'(d1_dy) <<< S;
      ox_num_r <= NUM1W'(p_rzlx) - NUM1W'(p_lzrx);
      oy_num_r <= NUM1W'(p_rzly) - NUM1W'(p_lzry);
      dz3_r    <= d1_dz;
      flat3_r  <= d1_dz == '0;
      rx3_r    <= d1_rx;
      ry3_r    <= d1_ry;
    end
  end

  // Line fit dividers, all by dz.
  logic signed [QB1:0] q_sx, q_sy, q_ox, q_oy;

  lpi_div #(.NW(NUM1W), .DW(DFW), .QB(QB1)) u_div_sx (
    .clk, .en(adv), .n(sx_num_r), .d(dz3_r), .flip(1'b0), .q(q_sx));
  lpi_div #(.NW(NUM1W), .DW(DFW), .QB(QB1)) u_div_sy (
    .clk, .en(adv), .n(sy_num_r), .d(dz3_r), .flip(1'b0), .q(q_sy));
  lpi_div #(.NW(NUM1W), .DW(DFW), .QB(QB1)) u_div_ox (
    .clk, .en(adv), .n(ox_num_r), .d(dz3_r), .flip(1'b0), .q(q_ox));
  lpi_div #(.NW(NUM1W), .DW(DFW), .QB(QB1)) u_div_oy (
    .clk, .en(adv), .n(oy_num_r), .d(dz3_r), .flip(1'b0), .q(q_oy));

  logic                 d2_v;
  logic [W2-1:0]        d2_d;
  logic                 d2_flat;
  logic signed [FW-1:0] d2_rx, d2_ry;

  lpi_delay #(.W(W2), .N(L1)) u_dly2 (
    .clk, .rst_n, .en(adv), .in_v(s3_v_r), .in_d({flat3_r, rx3_r, ry3_r}),
    .out_v(d2_v), .out_d(d2_d)
  );

  assign {d2_flat, d2_rx, d2_ry} = d2_d;

  // ---------------------------------------------------------------------------
  // Stage 4: saturated slopes and origins; equal z gives zero slopes and takes the second hit as origin.
  logic                 s4_v_r;
  logic signed [FW-1:0] sx4_r, sy4_r, sx4_nxt, sy4_nxt;
  logic signed [P-1:0]  ox4_r, oy4_r, ox4_nxt, oy4_nxt;
  logic                 flat4_r;

  assign sx4_nxt = d2_flat ? '0 : FW'(sat_w(SAT_W'(q_sx), FW));
  assign sy4_nxt = d2_flat ? '0 : FW'(sat_w(SAT_W'(q_sy), FW));
  assign ox4_nxt = d2_flat ? P'(sat_w(SAT_W'(d2_rx), P)) : P'(sat_w(SAT_W'(q_ox), P));
  assign oy4_nxt = d2_flat ? P'(sat_w(SAT_W'(d2_ry), P)) : P'(sat_w(SAT_W'(q_oy), P));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4_r   <= sx4_nxt;
      sy4_r   <= sy4_nxt;
      ox4_r   <= ox4_nxt;
      oy4_r   <= oy4_nxt;
      flat4_r <= d2_flat;
    end
  end

  // Plane products.
  logic signed [P+FW-1:0] p_aox, p_boy;
  logic signed [PRW-1:0]  p_asx, p_bsy;

  lpi_mul #(.AW(P), .BW(FW)) u_mul_aox (.clk, .en(adv), .a(ox4_r), .b(tilt_x_r), .p(p_aox));
  lpi_mul #(.AW(P), .BW(FW)) u_mul_boy (.clk, .en(adv), .a(oy4_r), .b(tilt_y_r), .p(p_boy));
  lpi_mul #(.AW(FW), .BW(FW)) u_mul_asx (.clk, .en(adv), .a(sx4_r), .b(tilt_x_r), .p(p_asx));
  lpi_mul #(.AW(FW), .BW(FW)) u_mul_bsy (.clk, .en(adv), .a(sy4_r), .b(tilt_y_r), .p(p_bsy));

  logic          d3_v;
  logic [W3-1:0] d3_d;

  lpi_delay #(.W(W3), .N(2)) u_dly3 (
    .clk, .rst_n, .en(adv), .in_v(s4_v_r),
    .in_d({sx4_r, sy4_r, ox4_r, oy4_r, flat4_r}),
    .out_v(d3_v), .out_d(d3_d)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: crossing numerator and denominator.
  logic                   s5_v_r;
  logic signed [NUMW-1:0] num5_r;
  logic signed [DENW-1:0] den5_r;
  logic [W3-1:0]          line5_r;
  logic signed [FW-1:0]   sx5, sy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= d3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num5_r  <= NUMW'(p_aox) + NUMW'(p_boy) + (NUMW'(offset_r) <<< S);
      den5_r  <= DENW'(p_asx) + DENW'(p_bsy) + DEN_ONE;
      line5_r <= d3_d;
    end
  end

  assign sx5 = $signed(line5_r[W3-1 -: FW]);
  assign sy5 = $signed(line5_r[W3-FW-1 -: FW]);

  // Numerator times slope.
  logic signed [NUMW+FW-1:0] p_nsx, p_nsy;

  lpi_mul #(.AW(NUMW), .BW(FW)) u_mul_nsx (.clk, .en(adv), .a(num5_r), .b(sx5), .p(p_nsx));
  lpi_mul #(.AW(NUMW), .BW(FW)) u_mul_nsy (.clk, .en(adv), .a(num5_r), .b(sy5), .p(p_nsy));

  logic                   d4_v;
  logic [W4-1:0]          d4_d;
  logic signed [NUMW-1:0] d4_num;
  logic signed [DENW-1:0] d4_den;
  logic [W3-1:0]          d4_line;

  lpi_delay #(.W(W4), .N(2)) u_dly4 (
    .clk, .rst_n, .en(adv), .in_v(s5_v_r), .in_d({num5_r, den5_r, line5_r}),
    .out_v(d4_v), .out_d(d4_d)
  );

  assign {d4_num, d4_den, d4_line} = d4_d;

  // Crossing dividers by den; the quotient sign is flipped for the negated dividends.
  logic signed [NUM2W-1:0] nx_w, ny_w, nz_w;
  logic signed [QB2:0]     q_cx, q_cy, q_cz;

  assign nx_w = NUM2W'(p_nsx);
  assign ny_w = NUM2W'(p_nsy);
  assign nz_w = NUM2W'(d4_num) <<< S;

  lpi_div #(.NW(NUM2W), .DW(DENW), .QB(QB2)) u_div_cx (
    .clk, .en(adv), .n(nx_w), .d(d4_den), .flip(1'b1), .q(q_cx));
  lpi_div #(.NW(NUM2W), .DW(DENW), .QB(QB2)) u_div_cy (
    .clk, .en(adv), .n(ny_w), .d(d4_den), .flip(1'b1), .q(q_cy));
  lpi_div #(.NW(NUM2W), .DW(DENW), .QB(QB2)) u_div_cz (
    .clk, .en(adv), .n(nz_w), .d(d4_den), .flip(1'b1), .q(q_cz));

  logic                 d5_v;
  logic [W5-1:0]        d5_d;
  logic signed [FW-1:0] sx6, sy6;
  logic signed [P-1:0]  ox6, oy6;
  logic                 flat6, nocross6;

  lpi_delay #(.W(W5), .N(L2)) u_dly5 (
    .clk, .rst_n, .en(adv), .in_v(d4_v), .in_d({d4_line, d4_den == '0}),
    .out_v(d5_v), .out_d(d5_d)
  );

  assign {sx6, sy6, ox6, oy6, flat6, nocross6} = d5_d;

  // ---------------------------------------------------------------------------
  // Final result: crossing point, zero when the line runs parallel to the plane.
  logic signed [P-1:0] cx_nxt, cy_nxt, cz_nxt;
  lpi_result_t         res_nxt;

  assign cx_nxt = nocross6 ? '0 : P'(sat_w(SAT_W'(q_cx) + SAT_W'(ox6), P));
  assign cy_nxt = nocross6 ? '0 : P'(sat_w(SAT_W'(q_cy) + SAT_W'(oy6), P));
  assign cz_nxt = nocross6 ? '0 : P'(sat_w(SAT_W'(q_cz), P));

  always_comb begin
    res_nxt.slope_x     = sx6;
    res_nxt.slope_y     = sy6;
    res_nxt.origin_x    = FW'(ox6);
    res_nxt.origin_y    = FW'(oy6);
    res_nxt.cross_x     = FW'(cx_nxt);
    res_nxt.cross_y     = FW'(cy_nxt);
    res_nxt.cross_z     = FW'(cz_nxt);
    res_nxt.flat_pair   = flat6;
    res_nxt.no_crossing = nocross6;
  end

  // ---------------------------------------------------------------------------
  // Output register with a skid register behind it.
  lpi_result_t out_r, skid_r;
  logic        out_v_r, skid_v_r;
  logic        out_free, arrive;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;
  assign out_free = !out_v_r || !out_stall;
  assign arrive   = d5_v && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= arrive;
      end
    end else if (arrive) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (arrive) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_slope_x     = out_r.slope_x;
  assign out_slope_y     = out_r.slope_y;
  assign out_origin_x    = out_r.origin_x;
  assign out_origin_y    = out_r.origin_y;
  assign out_cross_x     = out_r.cross_x;
  assign out_cross_y     = out_r.cross_y;
  assign out_cross_z     = out_r.cross_z;
  assign out_flat_pair   = out_r.flat_pair;
  assign out_no_crossing = out_r.no_crossing;

  // ---------------------------------------------------------------------------
  // Assertions.

  // The skid register only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a transaction with the output empty");

  // A held skid transaction stays put while the receiver stalls.
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_stall |=> skid_v_r && $stable(skid_r))
    else $error("skid transaction lost during a stall");

  // Equal z gives zero slopes.
  a_flat_slopes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flat_pair |-> out_slope_x == '0 && out_slope_y == '0)
    else $error("flat pair with nonzero slope");

  // A parallel line gives a zero crossing.
  a_nocross_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_crossing |->
      out_cross_x == '0 && out_cross_y == '0 && out_cross_z == '0)
    else $error("parallel line with nonzero crossing");

endmodule

`default_nettype wire
